/* rtl/wavhp_pkg.sv */
// Shared types and constants for the WAV header parser.
package wavhp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned ECODE_W   = 3;
    localparam int unsigned M_TDATA_W = 144;

    // Tags as they arrive, little-endian, first byte lowest
    localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;
    localparam logic [WORD_W-1:0] FMT_BASE = 32'd16;

    localparam logic [WORD_W-1:0] PCM_FORMAT   = 32'd1;
    localparam logic [WORD_W-1:0] MONO_CHANNEL = 32'd1;
    localparam logic [WORD_W-1:0] SAMPLE_BITS  = 32'd8;

    typedef enum logic [14:0] {
        PH_RIFF   = 15'b000_0000_0000_0001,
        PH_CSIZE  = 15'b000_0000_0000_0010,
        PH_WAVE   = 15'b000_0000_0000_0100,
        PH_FMT    = 15'b000_0000_0000_1000,
        PH_FSIZE  = 15'b000_0000_0001_0000,
        PH_AFMT   = 15'b000_0000_0010_0000,
        PH_CHAN   = 15'b000_0000_0100_0000,
        PH_SRATE  = 15'b000_0000_1000_0000,
        PH_BRATE  = 15'b000_0001_0000_0000,
        PH_ALIGN  = 15'b000_0010_0000_0000,
        PH_WIDTH  = 15'b000_0100_0000_0000,
        PH_SKIP   = 15'b000_1000_0000_0000,
        PH_DATA   = 15'b001_0000_0000_0000,
        PH_DSIZE  = 15'b010_0000_0000_0000,
        PH_STREAM = 15'b100_0000_0000_0000
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [ECODE_W-1:0] {
        ERR_NO_RIFF  = 3'd0,
        ERR_NOT_WAVE = 3'd1,
        ERR_NO_FMT   = 3'd2,
        ERR_NOT_PCM  = 3'd3,
        ERR_NOT_MONO = 3'd4,
        ERR_NOT_8BIT = 3'd5,
        ERR_NO_DATA  = 3'd6
    } err_code_t;

    typedef struct packed {
        kind_t              kind;
        err_code_t          error_code;
        logic [WORD_W-1:0]  chunk_size;
        logic [WORD_W-1:0]  sample_rate;
        logic [WORD_W-1:0]  byte_rate;
        logic [WORD_W-1:0]  data_size;
        logic [BYTE_W-1:0]  sample;
    } result_t;

endpackage

/* rtl/wavhp_in_stage.sv */
// Input register stage holding one file byte and its start flag.
module wavhp_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [wavhp_pkg::BYTE_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        take,
    output logic                        item_valid,
    output logic [wavhp_pkg::BYTE_W-1:0] item_byte,
    output logic                        item_sof
);
    import wavhp_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              sof_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_sof   = sof_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            sof_reg  <= s_tuser;
        end
    end

endmodule

/* rtl/wavhp_core.sv */
// Header parsing state and per-byte next-state and result logic.
module wavhp_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         consume,
    input  logic [wavhp_pkg::BYTE_W-1:0] in_byte,
    input  logic                         in_sof,
    output logic                         res_valid,
    output wavhp_pkg::result_t           res
);
    import wavhp_pkg::*;

    phase_t            phase_reg, phase_next, ph;
    logic [1:0]        cnt_reg, cnt_next, cnt, cnt_inc;
    logic [WORD_W-1:0] acc_reg, acc_next, acc, acc_shift;
    logic [WORD_W-1:0] exc_reg, exc_next, exc;
    logic [WORD_W-1:0] csize_reg, csize_next, csize;
    logic [WORD_W-1:0] srate_reg, srate_next, srate;
    logic [WORD_W-1:0] brate_reg, brate_next, brate;
    logic              err_reg, err_next, err;
    logic              len2, done;
    logic [WORD_W-1:0] val;

    // Start of file restarts the parser before the byte is used
    assign ph    = in_sof ? PH_RIFF : phase_reg;
    assign cnt   = in_sof ? 2'd0 : cnt_reg;
    assign acc   = in_sof ? '0 : acc_reg;
    assign exc   = in_sof ? '0 : exc_reg;
    assign csize = in_sof ? '0 : csize_reg;
    assign srate = in_sof ? '0 : srate_reg;
    assign brate = in_sof ? '0 : brate_reg;
    assign err   = in_sof ? 1'b0 : err_reg;

    assign acc_shift = {in_byte, acc[WORD_W-1:BYTE_W]};
    assign cnt_inc   = cnt + 2'd1;
    assign len2      = ph inside {PH_AFMT, PH_CHAN, PH_ALIGN, PH_WIDTH};
    assign done      = (cnt_inc == 2'd0) || (len2 && (cnt_inc == 2'd2));
    assign val       = len2 ? {16'h0000, acc_shift[WORD_W-1:16]} : acc_shift;

    always_comb begin
        phase_next = ph;
        cnt_next   = cnt;
        acc_next   = acc;
        exc_next   = exc;
        csize_next = csize;
        srate_next = srate;
        brate_next = brate;
        err_next   = err;
        res_valid  = 1'b0;
        res        = '0;
        if (!err) begin
            case (ph)
                PH_STREAM: begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_SAMPLE;
                    res.sample = in_byte;
                end
                PH_SKIP: begin
                    exc_next = (exc != '0) ? exc - 32'd1 : exc;
                    if (exc <= 32'd1) begin
                        phase_next = PH_DATA;
                    end
                end
                PH_RIFF, PH_CSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_AFMT, PH_CHAN,
                PH_SRATE, PH_BRATE, PH_ALIGN, PH_WIDTH, PH_DATA, PH_DSIZE: begin
                    acc_next = acc_shift;
                    cnt_next = done ? 2'd0 : cnt_inc;
                    if (done) begin
                        phase_next = phase_t'(ph << 1);
                        case (ph)
                            PH_RIFF: begin
                                if (val != TAG_RIFF) begin
                                    res.error_code = ERR_NO_RIFF;
                                    res_valid      = 1'b1;
                                end
                            end
                            PH_CSIZE: csize_next = val;
                            PH_WAVE: begin
                                if (val != TAG_WAVE) begin
                                    res.error_code = ERR_NOT_WAVE;
                                    res_valid      = 1'b1;
                                end
                            end
                            PH_FMT: begin
                                if (val != TAG_FMT) begin
                                    res.error_code = ERR_NO_FMT;
                                    res_valid      = 1'b1;
                                end
                            end
                            PH_FSIZE: exc_next = (val > FMT_BASE) ? val - FMT_BASE : '0;
                            PH_AFMT: begin
                                if (val != PCM_FORMAT) begin
                                    res.error_code = ERR_NOT_PCM;
                                    res_valid      = 1'b1;
                                end
                            end
                            PH_CHAN: begin
                                if (val != MONO_CHANNEL) begin
                                    res.error_code = ERR_NOT_MONO;
                                    res_valid      = 1'b1;
                                end
                            end
                            PH_SRATE: srate_next = val;
                            PH_BRATE: brate_next = val;
                            PH_WIDTH: begin
                                if (val != SAMPLE_BITS) begin
                                    res.error_code = ERR_NOT_8BIT;
                                    res_valid      = 1'b1;
                                end else begin
                                    phase_next = (exc != '0) ? PH_SKIP : PH_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (val != TAG_DATA) begin
                                    res.error_code = ERR_NO_DATA;
                                    res_valid      = 1'b1;
                                end
                            end
                            PH_DSIZE: begin
                                res_valid       = 1'b1;
                                res.kind        = KIND_HEADER;
                                res.chunk_size  = csize;
                                res.sample_rate = srate;
                                res.byte_rate   = brate;
                                res.data_size   = val;
                            end
                            default: ;
                        endcase
                        // A failed check holds the phase and latches the error
                        if (res_valid && (ph != PH_DSIZE)) begin
                            res.kind   = KIND_ERROR;
                            err_next   = 1'b1;
                            phase_next = ph;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF;
            cnt_reg   <= 2'd0;
            acc_reg   <= '0;
            exc_reg   <= '0;
            csize_reg <= '0;
            srate_reg <= '0;
            brate_reg <= '0;
            err_reg   <= 1'b0;
        end else if (consume) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            exc_reg   <= exc_next;
            csize_reg <= csize_next;
            srate_reg <= srate_next;
            brate_reg <= brate_next;
            err_reg   <= err_next;
        end
    end

    a_error_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && res_valid && (res.kind == KIND_ERROR) |=> err_reg)
        else $error("error result did not latch sticky error");

    a_error_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && err_reg && !in_sof |-> !res_valid)
        else $error("result produced after sticky error");

    a_sample_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && res_valid && (res.kind == KIND_SAMPLE)
            |-> (phase_reg == PH_STREAM) && !in_sof)
        else $error("sample emitted outside the data stream");

endmodule

/* rtl/wavhp_out_stage.sv */
// Result register stage driving the master stream.
module wavhp_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  wavhp_pkg::result_t              res,
    output logic                            can_take,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wavhp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [wavhp_pkg::KIND_W-1:0]    m_tuser
);
    import wavhp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_take = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {5'b00000, res_reg.sample, res_reg.data_size, res_reg.byte_rate,
                       res_reg.sample_rate, res_reg.chunk_size, res_reg.error_code};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

/* rtl/wav_header_parser.sv */
// Top level of the streaming WAV header parser.
//
// Feed a WAV file one byte per item on the slave stream, with s_tuser high on
// the first byte of each file to restart parsing. The block checks the RIFF,
// WAVE, 'fmt ' and 'data' tags, requires PCM, mono, 8-bit audio, skips any
// fmt bytes past the first 16, and then emits one header item (kind 0) with
// chunk size, sample rate, byte rate and data size. Every later byte comes
// out as a sample item (kind 1); the data size is reported, not enforced.
// The first failed check emits one error item (kind 2) and mutes the block
// until the next start of file. Throughput is one byte per clock unless a
// full result register waits on m_tready: each byte passes an input
// register, combinational parsing logic and a result register. Header bytes
// and skipped bytes produce no item. s_tready follows m_tready only while
// both registers are full.
module wav_header_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: [7:0] file_byte
    input  logic [wavhp_pkg::BYTE_W-1:0]    s_tdata,
    // s_tuser: [0] start_of_file
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: [2:0] error_code, [34:3] chunk_size, [66:35] sample_rate,
    //          [98:67] byte_rate, [130:99] data_size, [138:131] sample, rest zero
    output logic [wavhp_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: [1:0] kind
    output logic [wavhp_pkg::KIND_W-1:0]    m_tuser
);
    import wavhp_pkg::*;

    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              item_sof;
    logic              can_take;
    logic              consume;
    logic              res_valid;
    result_t           res;

    // Advance the held byte whenever the result register has room
    assign consume = item_valid && can_take;

    wavhp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (can_take),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_sof   (item_sof)
    );

    wavhp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (consume),
        .in_byte   (item_byte),
        .in_sof    (item_sof),
        .res_valid (res_valid),
        .res       (res)
    );

    // Load a result only for bytes that produce one; others just drain
    wavhp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && res_valid),
        .res      (res),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
